@@ src/acbd_pkg.sv @@
// ----------------------------------------------------------------------------
// acbd_pkg
// Types, S-box tables and round functions for the AES-128 CBC decrypt block.
// ----------------------------------------------------------------------------
package acbd_pkg;

  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned BLOCK_BYTES = 16;

  typedef logic [127:0] blk_t;
  typedef blk_t [NUM_ROUNDS:0] rkeys_t;
  typedef logic [7:0] sbox_t [256];

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_IV_HIGH  = 2'd2;
  localparam logic [1:0] REG_IV_LOW   = 2'd3;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [63:0] data;
  } cfg_t;

  typedef struct packed {
    blk_t block;
    blk_t chain;
    logic last;
  } item_t;

  typedef struct packed {
    blk_t       plain;
    logic [4:0] keep;
    logic       err;
    logic       eom;
  } res_t;

  localparam sbox_t FWD_SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // elaboration-time inversion of the forward table
  function automatic sbox_t invert_sbox(input sbox_t f);
    sbox_t inv;
    for (int i = 0; i < 256; i++) begin
      inv[f[i]] = 8'(i);
    end
    return inv;
  endfunction

  localparam sbox_t INV_SBOX = invert_sbox(FWD_SBOX);

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t inv_shift_sub(input blk_t s);
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (c * 4 + r) -: 8] = INV_SBOX[s[127 - 8 * (((c - r + 4) % 4) * 4 + r) -: 8]];
      end
    end
    return o;
  endfunction

  function automatic blk_t inv_mix(input blk_t s);
    blk_t o;
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        a[i]   = s[127 - 8 * (c * 4 + i) -: 8];
        x2     = xt(a[i]);
        x4     = xt(x2);
        x8     = xt(x4);
        m9[i]  = x8 ^ a[i];
        m11[i] = x8 ^ x2 ^ a[i];
        m13[i] = x8 ^ x4 ^ a[i];
        m14[i] = x8 ^ x4 ^ x2;
      end
      o[127 - 8 * (c * 4)     -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      o[127 - 8 * (c * 4 + 1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      o[127 - 8 * (c * 4 + 2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      o[127 - 8 * (c * 4 + 3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    return o;
  endfunction

  // one step of the AES-128 key schedule
  function automatic blk_t key_step(input blk_t w, input logic [7:0] rcon);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {FWD_SBOX[w[23:16]] ^ rcon, FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]], FWD_SBOX[w[31:24]]};
    w0 = w[127:96] ^ t;
    w1 = w[95:64] ^ w0;
    w2 = w[63:32] ^ w1;
    w3 = w[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

@@ src/acbd_fifo.sv @@
// ----------------------------------------------------------------------------
// acbd_fifo
// Small register FIFO with count-based full and empty.
// ----------------------------------------------------------------------------
module acbd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             we, re;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign we    = push & ~full;
  assign re    = pop & ~empty;
  assign dout  = mem[rptr_r];

  always_comb begin
    unique case ({we, re})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (we) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (re) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
    end
  end
endmodule

@@ src/acbd_keyexp.sv @@
// ----------------------------------------------------------------------------
// acbd_keyexp
// Key registers and sequential round-key expansion, one round key a cycle.
// ----------------------------------------------------------------------------
module acbd_keyexp (
  input  logic          clk,
  input  logic          rst_n,
  input  acbd_pkg::cfg_t cfg,
  output logic          busy,
  output acbd_pkg::rkeys_t rk
);
  import acbd_pkg::*;

  logic [63:0] key_hi_r, key_lo_r;
  logic        ld_r;
  logic [3:0]  cnt_r;
  logic [7:0]  rcon_r;
  blk_t        w_r, w_nxt;
  rkeys_t      rk_r;

  assign w_nxt = key_step(w_r, rcon_r);
  assign busy  = ld_r | (cnt_r != '0);
  assign rk    = rk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      ld_r     <= 1'b1;
      cnt_r    <= '0;
    end else begin
      ld_r <= 1'b0;
      if (cfg.we && cfg.index == REG_KEY_HIGH) begin
        key_hi_r <= cfg.data;
        ld_r     <= 1'b1;
      end
      if (cfg.we && cfg.index == REG_KEY_LOW) begin
        key_lo_r <= cfg.data;
        ld_r     <= 1'b1;
      end
      if (ld_r) begin
        cnt_r <= 4'd1;
      end else if (cnt_r != '0) begin
        cnt_r <= (cnt_r == 4'(NUM_ROUNDS)) ? '0 : cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_r) begin
      w_r    <= {key_hi_r, key_lo_r};
      rk_r[0] <= {key_hi_r, key_lo_r};
      rcon_r <= 8'h01;
    end else if (cnt_r != '0) begin
      w_r         <= w_nxt;
      rk_r[cnt_r] <= w_nxt;
      rcon_r      <= xt(rcon_r);
    end
  end
endmodule

@@ src/acbd_front.sv @@
// ----------------------------------------------------------------------------
// acbd_front
// Takes input beats, picks the chain value and queues work for the core.
// ----------------------------------------------------------------------------
module acbd_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  acbd_pkg::cfg_t cfg,
  input  logic           accept,
  input  acbd_pkg::blk_t block,
  input  logic           start,
  input  logic           last,
  output logic           q_full,
  input  logic           q_pop,
  output acbd_pkg::item_t q_item,
  output logic           q_empty
);
  import acbd_pkg::*;

  logic [63:0] iv_hi_r, iv_lo_r;
  blk_t        chain_r;
  item_t       push_item;
  logic [$bits(item_t)-1:0] q_dout;

  assign push_item.block = block;
  assign push_item.chain = start ? {iv_hi_r, iv_lo_r} : chain_r;
  assign push_item.last  = last;
  assign q_item          = item_t'(q_dout);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_hi_r <= '0;
      iv_lo_r <= '0;
      chain_r <= '0;
    end else begin
      if (cfg.we && cfg.index == REG_IV_HIGH) begin
        iv_hi_r <= cfg.data;
      end
      if (cfg.we && cfg.index == REG_IV_LOW) begin
        iv_lo_r <= cfg.data;
      end
      if (accept) begin
        chain_r <= block;
      end
    end
  end

  acbd_fifo #(.WIDTH($bits(item_t)), .DEPTH(DEPTH)) u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (push_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );
endmodule

@@ src/acbd_core.sv @@
// ----------------------------------------------------------------------------
// acbd_core
// Round-per-stage inverse cipher pipeline with CBC XOR and pad check.
// ----------------------------------------------------------------------------
module acbd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  acbd_pkg::rkeys_t rk,
  input  acbd_pkg::item_t  q_item,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic             res_full,
  output logic             res_we,
  output acbd_pkg::res_t   res
);
  import acbd_pkg::*;

  item_t                 st_r [NUM_ROUNDS];
  logic [NUM_ROUNDS-1:0] vld_r;
  logic                  adv;
  blk_t                  plain;
  logic [7:0]            pad;

  // whole pipe holds while the result queue is full
  assign adv   = ~res_full;
  assign q_pop = adv & ~q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_ROUNDS-2:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0].block <= q_item.block ^ rk[NUM_ROUNDS];
      st_r[0].chain <= q_item.chain;
      st_r[0].last  <= q_item.last;
    end
  end

  for (genvar k = 1; k < NUM_ROUNDS; k++) begin : g_round
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k].block <= inv_mix(inv_shift_sub(st_r[k-1].block) ^ rk[NUM_ROUNDS - k]);
        st_r[k].chain <= st_r[k-1].chain;
        st_r[k].last  <= st_r[k-1].last;
      end
    end
  end

  assign plain = inv_shift_sub(st_r[NUM_ROUNDS-1].block) ^ rk[0] ^ st_r[NUM_ROUNDS-1].chain;
  assign pad   = plain[7:0];

  always_comb begin
    res.plain = plain;
    res.eom   = st_r[NUM_ROUNDS-1].last;
    res.err   = st_r[NUM_ROUNDS-1].last && (pad > 8'(BLOCK_BYTES));
    if (!st_r[NUM_ROUNDS-1].last) begin
      res.keep = 5'(BLOCK_BYTES);
    end else if (res.err) begin
      res.keep = '0;
    end else begin
      res.keep = 5'(BLOCK_BYTES) - pad[4:0];
    end
  end

  assign res_we = adv & vld_r[NUM_ROUNDS-1];
endmodule

@@ src/aes128_cbc_decrypt_unpad.sv @@
// ----------------------------------------------------------------------------
// aes128_cbc_decrypt_unpad
// AES-128 CBC decryption with a PKCS#7-style pad-length check (a pad byte above 16 is an error), one block per beat.
// ----------------------------------------------------------------------------
// Path: input FIFO, then the ten round-pipeline registers, then result FIFO.
// Throughput: one block per cycle; the ten-stage round pipeline takes a beat
//   every cycle while the result queue has room.
// Reset: clears chain, IV and key (all zero); in_full stays high after reset
//   and after each key write while the round keys are expanded.
module aes128_cbc_decrypt_unpad #(
  parameter int unsigned IN_DEPTH  = 4,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        in_start_block,
  input  logic        in_last_block,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_plain_high,
  output logic [63:0] out_plain_low,
  output logic [4:0]  out_keep_bytes,
  output logic        out_pad_error,
  output logic        out_end_of_message,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import acbd_pkg::*;

  cfg_t   cfg;
  rkeys_t rk;
  item_t  q_item;
  res_t   res, out_res;
  logic   kbusy, q_full, q_empty, q_pop, res_we, res_full, accept;
  logic [$bits(res_t)-1:0] out_dout;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign in_full = q_full | kbusy;
  assign accept  = in_push & ~in_full;

  acbd_keyexp u_keyexp (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .busy  (kbusy),
    .rk    (rk)
  );

  acbd_front #(.DEPTH(IN_DEPTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .accept  (accept),
    .block   ({in_block_high, in_block_low}),
    .start   (in_start_block),
    .last    (in_last_block),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .q_empty (q_empty)
  );

  acbd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .rk       (rk),
    .q_item   (q_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_we   (res_we),
    .res      (res)
  );

  acbd_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_we),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_dout),
    .empty (out_empty)
  );

  assign out_res            = res_t'(out_dout);
  assign out_plain_high     = out_res.plain[127:64];
  assign out_plain_low      = out_res.plain[63:0];
  assign out_keep_bytes     = out_res.keep;
  assign out_pad_error      = out_res.err;
  assign out_end_of_message = out_res.eom;
endmodule

@@ src/acbd_checker.sv @@
// ----------------------------------------------------------------------------
// acbd_checker
// Port-level checks for the CBC decrypt block, bound to the top level.
// ----------------------------------------------------------------------------
module acbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [63:0] out_plain_high,
  input logic [63:0] out_plain_low,
  input logic [4:0]  out_keep_bytes,
  input logic        out_pad_error,
  input logic        out_end_of_message,
  input logic        cfg_we,
  input logic [1:0]  cfg_index
);
  import acbd_pkg::*;

  // key schedule is rebuilt after reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("in_full low right after reset");

  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW) |=> in_full)
    else $error("input open while round keys are stale");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_plain_high)
      && $stable(out_plain_low) && $stable(out_keep_bytes))
    else $error("waiting result changed");

  a_pad_err: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pad_error |-> out_end_of_message && out_keep_bytes == '0)
    else $error("pad error with bytes kept or not at end");

  a_full_blk: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_end_of_message |-> out_keep_bytes == 5'(BLOCK_BYTES) && !out_pad_error)
    else $error("middle block not full");
endmodule

bind aes128_cbc_decrypt_unpad acbd_checker u_acbd_checker (.*);

@@ bench/aes128_cbc_decrypt_unpad_tb.sv @@
// ----------------------------------------------------------------------------
// aes128_cbc_decrypt_unpad_tb
// Self-checking bench: an in-bench AES-128 inverse cipher, CBC chain and pad
// predictor feeds a scoreboard. Directed corner beats come first, then random
// messages, with bursty input, receiver stalls and key/IV changes.
// ----------------------------------------------------------------------------
module aes128_cbc_decrypt_unpad_tb;
  import acbd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    logic [63:0] ph;
    logic [63:0] pl;
    logic [4:0]  keep;
    logic        err;
    logic        eom;
  } plain_beat_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        start;
    logic        last;
  } cipher_beat_t;

  class plain_scoreboard;
    plain_beat_t pending_q[$];
    int errors = 0;

    function void note_input(plain_beat_t b);
      pending_q.push_back(b);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(plain_beat_t got);
      plain_beat_t exp_b;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected beat %h_%h", got.ph, got.pl));
        return;
      end
      exp_b = pending_q.pop_front();
      if (got.ph !== exp_b.ph) report($sformatf("plain_high %h exp %h", got.ph, exp_b.ph));
      if (got.pl !== exp_b.pl) report($sformatf("plain_low %h exp %h", got.pl, exp_b.pl));
      if (got.keep !== exp_b.keep) report($sformatf("keep %0d exp %0d", got.keep, exp_b.keep));
      if (got.err !== exp_b.err) report($sformatf("pad_error %b exp %b", got.err, exp_b.err));
      if (got.eom !== exp_b.eom) report($sformatf("eom %b exp %b", got.eom, exp_b.eom));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_push = 0;
  logic        in_full;
  logic [63:0] in_block_high = '0;
  logic [63:0] in_block_low = '0;
  logic        in_start_block = 0;
  logic        in_last_block = 0;
  logic        out_empty;
  logic        out_pop = 0;
  logic [63:0] out_plain_high;
  logic [63:0] out_plain_low;
  logic [4:0]  out_keep_bytes;
  logic        out_pad_error;
  logic        out_end_of_message;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;

  aes128_cbc_decrypt_unpad uut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  plain_scoreboard sb = new();
  int cycles = 0;
  int rx_hold = 0;
  int burst_left = 0;

  // predictor state
  logic [7:0]   sbox [256];
  logic [7:0]   isbox [256];
  logic [127:0] rkey [11];
  logic [63:0]  key_hi = '0, key_lo = '0, iv_hi = '0, iv_lo = '0;
  logic [127:0] chain = '0;

  function automatic logic [7:0] xt2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = xt2(a);
    end
    return r;
  endfunction

  // S-box from field inverse plus affine map
  function automatic void build_sboxes();
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 0;
      for (int y = 1; y < 256; y++)
        if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox[x] = b;
      isbox[b] = 8'(x);
    end
  endfunction

  function automatic void expand_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    logic [127:0] k;
    k = {key_hi, key_lo};
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = k[127 - 32 * i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i - 1];
      if (i % 4 == 0) begin
        t = {sbox[t[23:16]] ^ rc, sbox[t[15:8]], sbox[t[7:0]], sbox[t[31:24]]};
        rc = xt2(rc);
      end
      w[i] = w[i - 4] ^ t;
    end
    for (int r = 0; r < 11; r++) rkey[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
  endfunction

  function automatic logic [127:0] unshift_unsub(logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127 - 8 * (c * 4 + r) -: 8] = isbox[s[127 - 8 * (((c - r) & 3) * 4 + r) -: 8]];
    return o;
  endfunction

  function automatic logic [127:0] unmix(logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      o[127 - 32 * c -: 8] = gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9);
      o[119 - 32 * c -: 8] = gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13);
      o[111 - 32 * c -: 8] = gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11);
      o[103 - 32 * c -: 8] = gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14);
    end
    return o;
  endfunction

  function automatic logic [127:0] inv_cipher(logic [127:0] s);
    s ^= rkey[10];
    for (int r = 9; r >= 1; r--) begin
      s = unshift_unsub(s) ^ rkey[r];
      s = unmix(s);
    end
    return unshift_unsub(s) ^ rkey[0];
  endfunction

  function automatic plain_beat_t predict_plain(cipher_beat_t c);
    plain_beat_t b;
    logic [127:0] p;
    p = inv_cipher({c.hi, c.lo}) ^ (c.start ? {iv_hi, iv_lo} : chain);
    chain = {c.hi, c.lo};
    b.ph = p[127:64];
    b.pl = p[63:0];
    b.keep = 5'd16;
    b.err = 0;
    b.eom = c.last;
    if (c.last) begin
      if (p[7:0] > 8'd16) begin
        b.err = 1;
        b.keep = 0;
      end else b.keep = 5'(16 - p[7:0]);
    end
    return b;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_KEY_HIGH: begin key_hi = val; expand_keys(); end
      REG_KEY_LOW:  begin key_lo = val; expand_keys(); end
      REG_IV_HIGH:  iv_hi = val;
      default:      iv_lo = val;
    endcase
    @(posedge clk);
  endtask

  // stop offering and wait for every expected beat, then let the pipe settle
  task automatic drain();
    in_push <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_beat(cipher_beat_t c, bit bursty);
    if (bursty && burst_left == 0) begin
      int gap;
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_push <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_push <= 1;
    in_block_high <= c.hi;
    in_block_low <= c.lo;
    in_start_block <= c.start;
    in_last_block <= c.last;
    do @(negedge clk); while (in_full);
    @(posedge clk);
    sb.note_input(predict_plain(c));
    if (burst_left > 0) burst_left--;
  endtask

  // message with crafted pad byte on the last block (via previous block low byte)
  task automatic send_message(int len, int pad, bit bursty);
    cipher_beat_t m[$];
    cipher_beat_t c;
    logic [127:0] d;
    for (int i = 0; i < len; i++) begin
      c.hi = rand64();
      c.lo = rand64();
      c.start = (i == 0);
      c.last = (i == len - 1);
      m.push_back(c);
    end
    if (len > 1 && pad >= 0) begin
      d = inv_cipher({m[len - 1].hi, m[len - 1].lo});
      m[len - 2].lo[7:0] = d[7:0] ^ 8'(pad);
    end
    foreach (m[i]) send_beat(m[i], bursty);
  endtask

  task automatic load_config(logic [63:0] kh, logic [63:0] kl, logic [63:0] vh,
                             logic [63:0] vl);
    cfg_write(REG_KEY_HIGH, kh);
    cfg_write(REG_KEY_LOW, kl);
    cfg_write(REG_IV_HIGH, vh);
    cfg_write(REG_IV_LOW, vl);
  endtask

  // receiver: stall pattern is redrawn at random from four modes; rx_hold forces a long stall
  initial begin
    plain_beat_t got;
    int mode;
    mode = 0;
    forever begin
      @(negedge clk);
      if (out_pop && !out_empty) begin
        got.ph = out_plain_high;
        got.pl = out_plain_low;
        got.keep = out_keep_bytes;
        got.err = out_pad_error;
        got.eom = out_end_of_message;
        sb.check_result(got);
      end
      @(posedge clk);
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      if (rx_hold > 0) begin
        rx_hold--;
        out_pop <= 0;
      end else case (mode)
        0: out_pop <= 1;
        1: out_pop <= ($urandom_range(0, 1) == 0);
        2: out_pop <= ($urandom_range(0, 3) == 0);
        default: out_pop <= ((cycles % 8) < 5);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    cipher_beat_t c;
    build_sboxes();
    expand_keys();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset key, extreme blocks
    c = '{64'h0, 64'h0, 1'b1, 1'b0};
    send_beat(c, 0);
    c = '{'1, '1, 1'b0, 1'b1};
    send_beat(c, 0);
    c = '{'1, 64'h0, 1'b0, 1'b0};
    send_beat(c, 0);
    drain();
    load_config('1, '1, '1, '1);
    c = '{64'h0, '1, 1'b1, 1'b1};
    send_beat(c, 0);
    // pad zero, one, sixteen, seventeen, 0xff
    send_message(2, 0, 0);
    send_message(2, 1, 0);
    send_message(3, 16, 0);
    send_message(2, 17, 0);
    send_message(2, 255, 0);
    drain();
    // IV changed in the middle of a message: only the next start uses it
    load_config(rand64(), rand64(), rand64(), rand64());
    c = '{rand64(), rand64(), 1'b1, 1'b0};
    send_beat(c, 0);
    drain();
    cfg_write(REG_IV_HIGH, rand64());
    cfg_write(REG_IV_LOW, rand64());
    c = '{rand64(), rand64(), 1'b0, 1'b0};
    send_beat(c, 0);
    send_message(2, 5, 0);
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_config('0, '0, '0, '0);
        1: load_config('1, '1, '1, '1);
        default: load_config(rand64(), rand64(), rand64(), rand64());
      endcase
      if (ph == 2) begin
        // long receiver stall while the sender keeps offering
        rx_hold = 300;
        for (int i = 0; i < 40; i++) begin
          c = '{rand64(), rand64(), 1'(i == 0), 1'b0};
          send_beat(c, 0);
        end
      end
      for (int n = 0; n < 125; ) begin
        int len;
        if ($urandom_range(0, 9) == 0) begin
          // noise: arbitrary flags
          c = '{rand64(), rand64(), 1'($urandom), 1'($urandom)};
          send_beat(c, 1);
          n++;
        end else begin
          len = $urandom_range(1, 6);
          send_message(len, ($urandom_range(0, 7) == 0) ? $urandom_range(17, 255)
                                                          : $urandom_range(0, 16), 1);
          n += len;
        end
        if ($urandom_range(0, 40) == 0) drain();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
